@@ rtl/hbk_pkg.sv @@
// Shared types, constants and scancode tables for the HID boot keyboard
// to set-1 scancode converter. No dependencies; used by every module.
package hbk_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int SLOT_IW   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int IN_W      = 56;

	localparam logic [7:0] REPEAT_OFF = 8'hff;
	localparam logic [7:0] BREAK_BIT  = 8'h80;
	localparam logic [7:0] PAUSE_PFX  = 8'he1;
	localparam logic [7:0] PAUSE_B1   = 8'h1d;
	localparam logic [7:0] PAUSE_B2   = 8'h45;
	localparam logic [7:0] DELAY_RST  = 8'd16;
	localparam logic [7:0] TABLE_LEN  = 8'd100;

	// Code sources selected by the controller
	localparam logic [2:0] SRC_HELD = 3'd0;
	localparam logic [2:0] SRC_MODB = 3'd1;
	localparam logic [2:0] SRC_MODM = 3'd2;
	localparam logic [2:0] SRC_SLOT = 3'd3;
	localparam logic [2:0] SRC_REP  = 3'd4;

	localparam logic [15:0] USAGE_CODE [0:99] = '{
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001e, 16'h0030, 16'h002e, 16'h0020,
		16'h0012, 16'h0021, 16'h0022, 16'h0023, 16'h0017, 16'h0024, 16'h0025, 16'h0026,
		16'h0032, 16'h0031, 16'h0018, 16'h0019, 16'h0010, 16'h0013, 16'h001f, 16'h0014,
		16'h0016, 16'h002f, 16'h0011, 16'h002d, 16'h0015, 16'h002c, 16'h0002, 16'h0003,
		16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000a, 16'h000b,
		16'h001c, 16'h0001, 16'h000e, 16'h000f, 16'h0039, 16'h000c, 16'h000d, 16'h001a,
		16'h001b, 16'h002b, 16'h0000, 16'h0027, 16'h0028, 16'h0029, 16'h0033, 16'h0034,
		16'h0035, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f, 16'h0040,
		16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0057, 16'h0058, 16'he037, 16'h0046,
		16'he11d, 16'he052, 16'he047, 16'he049, 16'he053, 16'he04f, 16'he051, 16'he04d,
		16'he04b, 16'he050, 16'he048, 16'h0045, 16'he035, 16'h0037, 16'h004a, 16'h004e,
		16'he01c, 16'h004f, 16'h0050, 16'h0051, 16'h004b, 16'h004c, 16'h004d, 16'h0047,
		16'h0048, 16'h0049, 16'h0052, 16'h0053
	};

	localparam logic [15:0] MOD_CODE [0:7] = '{
		16'h001d, 16'h002a, 16'h0038, 16'he05b, 16'he01d, 16'h0036, 16'he038, 16'he05c
	};

	typedef struct packed {
		logic       load;
		logic [2:0] src;
		logic [2:0] idx;
		logic [1:0] ph;
		logic       emit;
		logic       keep;
		logic       drop;
		logic       mod_commit;
		logic       new_add;
		logic       new_term;
		logic       rep_dec;
		logic       finish;
	} hbk_cmd_t;

	typedef struct packed {
		logic       found;
		logic       elem_on;
		logic [1:0] code_len;
		logic       can_push;
		logic       pend_v;
		logic       out_free;
	} hbk_stat_t;

	function automatic logic [15:0] usage_to_code(input logic [7:0] u);
		logic [15:0] c;
		c = 16'h0000;
		if (u < TABLE_LEN) begin
			c = USAGE_CODE[u[6:0]];
		end
		return c;
	endfunction

	function automatic logic [1:0] code_len(input logic [15:0] c);
		logic [1:0] n;
		if (c == 16'h0000) begin
			n = 2'd0;
		end else if (c[15:8] == PAUSE_PFX) begin
			n = 2'd3;
		end else if (c[15:8] != 8'h00) begin
			n = 2'd2;
		end else begin
			n = 2'd1;
		end
		return n;
	endfunction

	function automatic logic [7:0] code_byte(input logic [15:0] c, input logic brk,
			input logic [1:0] ph);
		logic [7:0] b;
		logic [7:0] m;
		m = brk ? BREAK_BIT : 8'h00;
		if (c[15:8] == PAUSE_PFX) begin
			if (ph == 2'd0) begin
				b = PAUSE_PFX;
			end else if (ph == 2'd1) begin
				b = PAUSE_B1 | m;
			end else begin
				b = PAUSE_B2 | m;
			end
		end else if (c[15:8] != 8'h00 && ph == 2'd0) begin
			b = c[15:8];
		end else begin
			b = c[7:0] | m;
		end
		return b;
	endfunction

endpackage

@@ rtl/hbk_ctrl.sv @@
// Sequencer for the scancode converter: walks releases, modifier breaks,
// modifier makes, new presses and repeat. Depends on hbk_pkg.
module hbk_ctrl import hbk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  hbk_stat_t st,
	output hbk_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_REL  = 3'd1;
	localparam logic [2:0] ST_MODB = 3'd2;
	localparam logic [2:0] ST_MODM = 3'd3;
	localparam logic [2:0] ST_NEW  = 3'd4;
	localparam logic [2:0] ST_REP  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] idx_q, idx_d;
	logic [1:0] ph_q, ph_d;
	logic       last_ph;

	assign s_tready = (state_q == ST_IDLE);
	assign last_ph  = (ph_q == st.code_len - 2'd1);

	always_comb begin
		cmd     = '0;
		cmd.idx = idx_q;
		cmd.ph  = ph_q;
		state_d = state_q;
		idx_d   = idx_q;
		ph_d    = ph_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_REL;
					idx_d    = 3'd0;
					ph_d     = 2'd0;
				end
			end
			ST_REL: begin
				cmd.src = SRC_HELD;
				if (idx_q == 3'(KEY_SLOTS) || !st.elem_on) begin
					state_d = ST_MODB;
					idx_d   = 3'd0;
				end else if (st.found) begin
					cmd.keep = 1'b1;
					idx_d    = idx_q + 3'd1;
				end else if (st.code_len == 2'd0) begin
					cmd.drop = 1'b1;
					idx_d    = idx_q + 3'd1;
				end else if (st.can_push) begin
					cmd.emit = 1'b1;
					if (last_ph) begin
						cmd.drop = 1'b1;
						idx_d    = idx_q + 3'd1;
						ph_d     = 2'd0;
					end else begin
						ph_d = ph_q + 2'd1;
					end
				end
			end
			ST_MODB, ST_MODM: begin
				cmd.src = (state_q == ST_MODB) ? SRC_MODB : SRC_MODM;
				if (!st.elem_on || (st.can_push && last_ph)) begin
					cmd.emit = st.elem_on;
					ph_d     = 2'd0;
					if (idx_q == 3'd7) begin
						idx_d = 3'd0;
						if (state_q == ST_MODB) begin
							state_d = ST_MODM;
						end else begin
							cmd.mod_commit = 1'b1;
							state_d        = ST_NEW;
						end
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end else if (st.can_push) begin
					cmd.emit = 1'b1;
					ph_d     = ph_q + 2'd1;
				end
			end
			ST_NEW: begin
				cmd.src = SRC_SLOT;
				if (idx_q == 3'(KEY_SLOTS)) begin
					cmd.new_term = 1'b1;
					state_d      = ST_REP;
				end else if (!st.elem_on) begin
					idx_d = idx_q + 3'd1;
				end else if (st.code_len == 2'd0) begin
					cmd.new_add = 1'b1;
					idx_d       = idx_q + 3'd1;
				end else if (st.can_push) begin
					cmd.emit = 1'b1;
					if (last_ph) begin
						cmd.new_add = 1'b1;
						idx_d       = idx_q + 3'd1;
						ph_d        = 2'd0;
					end else begin
						ph_d = ph_q + 2'd1;
					end
				end
			end
			ST_REP: begin
				cmd.src = SRC_REP;
				if (!st.elem_on) begin
					cmd.rep_dec = 1'b1;
					state_d     = ST_FIN;
				end else if (st.code_len == 2'd0) begin
					state_d = ST_FIN;
				end else if (st.can_push) begin
					cmd.emit = 1'b1;
					if (last_ph) begin
						state_d = ST_FIN;
						ph_d    = 2'd0;
					end else begin
						ph_d = ph_q + 2'd1;
					end
				end
			end
			ST_FIN: begin
				if (!st.pend_v) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 3'd0;
			ph_q    <= 2'd0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			ph_q    <= ph_d;
		end
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_REL && idx_q == 3'd0))
		else $error("report accepted but release walk not started");

	a_ph_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != 2'd3))
		else $error("byte phase out of range");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!cmd.emit && !cmd.finish))
		else $error("byte produced while idle");

endmodule

@@ rtl/hbk_datapath.sv @@
// Datapath for the scancode converter: held key list, modifier and repeat
// state, code tables and the output byte registers. Depends on hbk_pkg.
module hbk_datapath import hbk_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [IN_W-1:0] s_tdata,
	input  logic            cfg_valid,
	input  logic [7:0]      cfg_data,
	input  logic            m_tready,
	input  hbk_cmd_t        cmd,
	output hbk_stat_t       st,
	output logic            m_tvalid,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	logic [7:0] held_q [KEY_SLOTS];
	logic [7:0] slot_q [KEY_SLOTS];
	logic [7:0] mods_q, mods_in_q, rep_q, delay_q;
	logic [3:0] addpos_q;
	logic [7:0] pend_q;
	logic       pend_v_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_v_q;

	logic [7:0]         cur_key, sel_usage, mod_mask;
	logic [15:0]        sel_code;
	logic               sel_brk, elem_on, found, drop_last;
	logic [SLOT_IW-1:0] match_j;
	logic [3:0]         nxt, rep_pos;
	logic               can_push, out_free;

	assign out_free = !out_v_q || m_tready;
	assign can_push = !pend_v_q || out_free;
	assign nxt      = {1'b0, cmd.idx} + 4'd1;
	assign rep_pos  = addpos_q - 4'd1;

	always_comb begin
		cur_key   = 8'h00;
		sel_usage = 8'h00;
		sel_code  = 16'h0000;
		sel_brk   = 1'b0;
		elem_on   = 1'b0;
		mod_mask  = 8'h00;
		found     = 1'b0;
		match_j   = '0;
		drop_last = 1'b1;
		if (cmd.idx < 3'(KEY_SLOTS)) begin
			cur_key = held_q[cmd.idx[SLOT_IW-1:0]];
		end
		for (int j = 0; j < KEY_SLOTS; j++) begin
			if (!found && slot_q[j] == cur_key) begin
				found   = 1'b1;
				match_j = SLOT_IW'(j);
			end
		end
		if (nxt < 4'(KEY_SLOTS)) begin
			drop_last = (held_q[nxt[SLOT_IW-1:0]] == 8'h00);
		end
		unique case (cmd.src)
			SRC_HELD: begin
				sel_usage = cur_key;
				sel_code  = usage_to_code(sel_usage);
				sel_brk   = 1'b1;
				elem_on   = (cur_key != 8'h00);
			end
			SRC_MODB, SRC_MODM: begin
				mod_mask = (cmd.src == SRC_MODB) ? (mods_q & ~mods_in_q)
					: (mods_in_q & ~mods_q);
				sel_code = MOD_CODE[cmd.idx];
				sel_brk  = (cmd.src == SRC_MODB);
				elem_on  = mod_mask[cmd.idx];
			end
			SRC_SLOT: begin
				if (cmd.idx < 3'(KEY_SLOTS)) begin
					sel_usage = slot_q[cmd.idx[SLOT_IW-1:0]];
				end
				sel_code = usage_to_code(sel_usage);
				elem_on  = (sel_usage != 8'h00);
			end
			SRC_REP: begin
				if (addpos_q != 4'd0) begin
					sel_usage = held_q[rep_pos[SLOT_IW-1:0]];
				end
				sel_code = usage_to_code(sel_usage);
				elem_on  = (addpos_q != 4'd0) && (rep_q == 8'h00);
			end
			default: begin
				sel_code = 16'h0000;
			end
		endcase
	end

	assign st.found    = found && (cmd.src == SRC_HELD) && (cur_key != 8'h00);
	assign st.elem_on  = elem_on;
	assign st.code_len = code_len(sel_code);
	assign st.can_push = can_push;
	assign st.pend_v   = pend_v_q;
	assign st.out_free = out_free;

	// Key list, modifiers and repeat state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				held_q[i] <= 8'h00;
			end
			mods_q   <= 8'h00;
			rep_q    <= 8'h00;
			delay_q  <= DELAY_RST;
			addpos_q <= 4'd0;
		end else begin
			if (cfg_valid) begin
				delay_q <= cfg_data;
			end
			if (cmd.load) begin
				addpos_q <= 4'd0;
			end
			if (cmd.keep) begin
				held_q[addpos_q[SLOT_IW-1:0]] <= cur_key;
				addpos_q                      <= addpos_q + 4'd1;
			end
			if (cmd.drop && drop_last) begin
				rep_q <= REPEAT_OFF;
			end
			if (cmd.mod_commit) begin
				mods_q <= mods_in_q;
			end
			if (cmd.new_add) begin
				if (addpos_q < 4'(KEY_SLOTS)) begin
					held_q[addpos_q[SLOT_IW-1:0]] <= sel_usage;
					addpos_q                      <= addpos_q + 4'd1;
				end
				rep_q <= delay_q;
			end
			if (cmd.new_term && addpos_q < 4'(KEY_SLOTS)) begin
				held_q[addpos_q[SLOT_IW-1:0]] <= 8'h00;
			end
			if (cmd.rep_dec && addpos_q != 4'd0 && rep_q != 8'h00 && rep_q != REPEAT_OFF) begin
				rep_q <= rep_q - 8'd1;
			end
		end
	end

	// Captured report; slots are consumed as held keys match them
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mods_in_q <= s_tdata[7:0];
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slot_q[i] <= s_tdata[8*(i+1) +: 8];
			end
		end else if (cmd.keep) begin
			slot_q[match_j] <= 8'h00;
		end
	end

	// One byte of look-ahead so the final byte can carry the last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else if (cmd.finish) begin
			out_v_q  <= 1'b1;
			pend_v_q <= 1'b0;
		end else if (cmd.emit) begin
			pend_v_q <= 1'b1;
			if (pend_v_q) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_byte_q <= pend_q;
			out_last_q <= 1'b1;
		end else if (cmd.emit && pend_v_q) begin
			out_byte_q <= pend_q;
			out_last_q <= 1'b0;
		end
		if (cmd.emit) begin
			pend_q <= code_byte(sel_code, sel_brk, cmd.ph);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && !can_push))
		else $error("byte produced while output register is blocked");

	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(addpos_q <= 4'(KEY_SLOTS)))
		else $error("held list overflow");

	a_emit_pends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> pend_v_q)
		else $error("emitted byte not held");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (m_tvalid && m_tlast && !pend_v_q))
		else $error("final byte not presented with last flag");

endmodule

@@ rtl/hid_boot_keyboard_to_scancode_core.sv @@
// Top level of the HID boot keyboard to set-1 scancode converter.
// Depends on hbk_pkg, hbk_ctrl and hbk_datapath.
//  - s_* channel: one boot keyboard report per item, taken when s_tvalid and
//    s_tready are both high; s_tready is high only while the sequencer idles.
//  - m_* channel: the scancode bytes of that report, one per item, in the
//    order key breaks, modifier breaks, modifier makes, key makes, repeat.
//    m_tlast marks the final byte; a report with nothing to say gives none.
//  - cfg_* channel: repeat delay in reports; always ready, write only while
//    no report is in flight.
// Flow: a report holds the sequencer while its key breaks, modifier breaks,
// modifier makes, key makes and repeat are walked; no new report is taken
// until it returns to idle. One byte is held back so that the last flag is
// known: the first byte is presented once the second is formed, or at the
// closing flush if it is the only one. Stall: a blocked receiver holds the
// sequencer on its current byte; nothing is dropped. Reset empties the held
// list, clears modifiers and the repeat counter, and sets the repeat delay
// to 16.
module hid_boot_keyboard_to_scancode_core import hbk_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	// [7:0] modifier_bits, [15:8] key_slot_0, [23:16] key_slot_1,
	// [31:24] key_slot_2, [39:32] key_slot_3, [47:40] key_slot_4,
	// [55:48] key_slot_5
	input  logic [IN_W-1:0] s_tdata,
	output logic            m_tvalid,
	input  logic            m_tready,
	// [7:0] scan_byte
	output logic [7:0]      m_tdata,
	output logic            m_tlast,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	// [7:0] repeat_delay_reports
	input  logic [7:0]      cfg_data
);

	hbk_cmd_t  cmd;
	hbk_stat_t st;

	// Register writes are never held off
	assign cfg_ready = 1'b1;

	hbk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	hbk_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.st        (st),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

@@ sim/tb_hid_boot_keyboard_to_scancode_core.sv @@
// Self-checking testbench for hid_boot_keyboard_to_scancode_core: boot keyboard
// reports go in on the s_* stream, set-1 scancode bytes are checked on m_* against
// a predictor kept here. Depends on hbk_pkg and the core RTL only.
module tb_hid_boot_keyboard_to_scancode_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RPT_W        = hbk_pkg::IN_W;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 160;
	localparam int MAX_BURST    = 55;
	localparam int RANDOM_RUN   = 18;

	localparam logic [7:0] NO_REPEAT = 8'hff;
	localparam logic [7:0] BRK_MASK  = 8'h80;
	localparam logic [7:0] PAUSE_E1  = 8'he1;
	localparam logic [7:0] PAUSE_1D  = 8'h1d;
	localparam logic [7:0] PAUSE_45  = 8'h45;
	localparam int         NUM_CODED = 100;

	// Usage code to set-1 code; a high byte of e0 is a prefix, e1 is Pause.
	localparam logic [15:0] SET1_OF_USAGE [0:99] = '{
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001e, 16'h0030, 16'h002e, 16'h0020,
		16'h0012, 16'h0021, 16'h0022, 16'h0023, 16'h0017, 16'h0024, 16'h0025, 16'h0026,
		16'h0032, 16'h0031, 16'h0018, 16'h0019, 16'h0010, 16'h0013, 16'h001f, 16'h0014,
		16'h0016, 16'h002f, 16'h0011, 16'h002d, 16'h0015, 16'h002c, 16'h0002, 16'h0003,
		16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000a, 16'h000b,
		16'h001c, 16'h0001, 16'h000e, 16'h000f, 16'h0039, 16'h000c, 16'h000d, 16'h001a,
		16'h001b, 16'h002b, 16'h0000, 16'h0027, 16'h0028, 16'h0029, 16'h0033, 16'h0034,
		16'h0035, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f, 16'h0040,
		16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0057, 16'h0058, 16'he037, 16'h0046,
		16'he11d, 16'he052, 16'he047, 16'he049, 16'he053, 16'he04f, 16'he051, 16'he04d,
		16'he04b, 16'he050, 16'he048, 16'h0045, 16'he035, 16'h0037, 16'h004a, 16'h004e,
		16'he01c, 16'h004f, 16'h0050, 16'h0051, 16'h004b, 16'h004c, 16'h004d, 16'h0047,
		16'h0048, 16'h0049, 16'h0052, 16'h0053
	};

	// Modifier bit to set-1 code: lctl, lshift, lalt, lgui, rctl, rshift, ralt, rgui
	localparam logic [15:0] SET1_OF_MOD [0:7] = '{
		16'h001d, 16'h002a, 16'h0038, 16'he05b, 16'he01d, 16'h0036, 16'he038, 16'he05c
	};

	// Usage codes picked out for the directed part
	localparam logic [7:0] U_A       = 8'd4;
	localparam logic [7:0] U_B       = 8'd5;
	localparam logic [7:0] U_ONE     = 8'd30;
	localparam logic [7:0] U_PRTSC   = 8'd70;
	localparam logic [7:0] U_PAUSE   = 8'd72;
	localparam logic [7:0] U_RIGHT   = 8'd79;
	localparam logic [7:0] U_KP_DIV  = 8'd84;
	localparam logic [7:0] U_KP_ENT  = 8'd88;
	localparam logic [7:0] U_NONUS   = 8'd50;
	localparam logic [7:0] U_BEYOND  = 8'd100;

	typedef struct packed {
		logic [7:0] scan_byte;
		logic       last_byte;
	} scan_item_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [RPT_W-1:0] s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [7:0]       cfg_data  = 8'h00;

	// Predictor state: mirrors what the block keeps between reports
	logic [7:0] kb_held [0:5];
	logic [7:0] kb_mods;
	logic [7:0] kb_repeat;
	logic [7:0] kb_delay;

	logic [RPT_W-1:0] reports_to_send [$];
	logic [7:0]       burst_bytes [$];
	scan_item_t       pending_scancodes [$];
	scan_item_t       oldest;

	logic steady = 1'b0;
	int   error_count = 0;
	int   cycle_count = 0;

	hid_boot_keyboard_to_scancode_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		// [7:0] modifier_bits, [15:8] key_slot_0 ... [55:48] key_slot_5
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		// [7:0] scan_byte
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		// [7:0] repeat_delay_reports
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Drop anything past the burst limit of MAX_BURST bytes.
	function automatic void add_byte(input logic [7:0] b);
		if (burst_bytes.size() < MAX_BURST) begin
			burst_bytes.push_back(b);
		end
	endfunction

	// Break sets bit 7 of the code byte only, never of a prefix.
	function automatic void add_code(input logic [15:0] code, input logic brk);
		logic [7:0] m;
		m = brk ? BRK_MASK : 8'h00;
		if (code[15:8] == PAUSE_E1) begin
			add_byte(PAUSE_E1);
			add_byte(PAUSE_1D | m);
			add_byte(PAUSE_45 | m);
		end else begin
			if (code[15:8] != 8'h00) begin
				add_byte(code[15:8]);
			end
			add_byte(code[7:0] | m);
		end
	endfunction

	// Usages with no set-1 code say nothing but are still tracked by the caller.
	function automatic void add_usage(input logic [7:0] usage, input logic brk);
		if (usage < NUM_CODED && SET1_OF_USAGE[usage] != 16'h0000) begin
			add_code(SET1_OF_USAGE[usage], brk);
		end
	endfunction

	function automatic void add_mods(input logic [7:0] bits, input logic brk);
		for (int i = 0; i < 8; i++) begin
			if (bits[i]) begin
				add_code(SET1_OF_MOD[i], brk);
			end
		end
	endfunction

	function automatic void reset_keyboard_state();
		for (int i = 0; i < 6; i++) begin
			kb_held[i] = 8'h00;
		end
		kb_mods   = 8'h00;
		kb_repeat = 8'h00;
		kb_delay  = 8'd16;
	endfunction

	// Work out the scancode burst of one accepted report and queue it.
	function automatic void predict_scancodes(input logic [RPT_W-1:0] rpt);
		logic [7:0] slot [0:5];
		logic [7:0] mods;
		logic [7:0] k;
		logic       found;
		int         keep;
		burst_bytes.delete();
		mods = rpt[7:0];
		for (int i = 0; i < 6; i++) begin
			slot[i] = rpt[8*i+8 +: 8];
		end
		keep = 0;
		// Keep still-held keys packed in press order, break the rest.
		for (int i = 0; i < 6; i++) begin
			k = kb_held[i];
			if (k == 8'h00) begin
				break;
			end
			found = 1'b0;
			for (int j = 0; j < 6; j++) begin
				if (!found && slot[j] == k) begin
					slot[j] = 8'h00;
					kb_held[keep] = k;
					keep++;
					found = 1'b1;
				end
			end
			if (!found) begin
				add_usage(k, 1'b1);
				// Releasing the newest entry of the list switches repeat off
				if (i == 5) begin
					kb_repeat = NO_REPEAT;
				end else if (kb_held[i+1] == 8'h00) begin
					kb_repeat = NO_REPEAT;
				end
			end
		end
		add_mods(kb_mods & ~mods, 1'b1);
		add_mods(mods & ~kb_mods, 1'b0);
		kb_mods = mods;
		// Fresh presses in slot order, each one reloading the repeat delay
		for (int i = 0; i < 6; i++) begin
			if (slot[i] != 8'h00) begin
				add_usage(slot[i], 1'b0);
				if (keep < 6) begin
					kb_held[keep] = slot[i];
					keep++;
				end
				kb_repeat = kb_delay;
			end
		end
		if (keep < 6) begin
			kb_held[keep] = 8'h00;
		end
		if (keep > 0) begin
			if (kb_repeat == 8'h00) begin
				add_usage(kb_held[keep-1], 1'b0);
			end else if (kb_repeat != NO_REPEAT) begin
				kb_repeat--;
			end
		end
		for (int n = 0; n < burst_bytes.size(); n++) begin
			pending_scancodes.push_back('{burst_bytes[n], n == burst_bytes.size() - 1});
		end
	endfunction

	// ------------------------------------------------------------------
	// Report driver: idles at random unless the steady window is open
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			// Predict at the edge that takes the report, so config is current
			if (s_tvalid && s_tready) begin
				predict_scancodes(s_tdata);
			end
			if (!s_tvalid || s_tready) begin
				if (reports_to_send.size() > 0 && (steady || $urandom_range(99) >= 17)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= reports_to_send.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Scancode monitor: stalls at random, checks every byte in order
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_scancodes.size() == 0) begin
					$error("scan_byte: expected nothing, actual %02h", m_tdata);
					error_count++;
				end else begin
					oldest = pending_scancodes.pop_front();
					if (m_tdata !== oldest.scan_byte) begin
						$error("scan_byte: expected %02h, actual %02h",
							oldest.scan_byte, m_tdata);
						error_count++;
					end
					if (m_tlast !== oldest.last_byte) begin
						$error("last_byte: expected %0b, actual %0b",
							oldest.last_byte, m_tlast);
						error_count++;
					end
				end
			end
			m_tready <= steady || ($urandom_range(99) >= 17);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [RPT_W-1:0] report(input logic [7:0] mods,
			input logic [7:0] k0, input logic [7:0] k1, input logic [7:0] k2,
			input logic [7:0] k3, input logic [7:0] k4, input logic [7:0] k5);
		return {k5, k4, k3, k2, k1, k0, mods};
	endfunction

	// Mostly real keys, some silent usages, some out of table.
	function automatic logic [7:0] pick_usage();
		int p;
		p = $urandom_range(99);
		if (p < 80) begin
			return 8'($urandom_range(4, 99));
		end else if (p < 90) begin
			return ($urandom_range(4) == 4) ? U_NONUS : 8'($urandom_range(0, 3));
		end
		return 8'($urandom_range(100, 255));
	endfunction

	// Evolve the previous report as a typist would; a tenth is pure noise.
	function automatic logic [RPT_W-1:0] next_report(input logic [RPT_W-1:0] prev);
		logic [RPT_W-1:0] r;
		int pick;
		int s;
		int b;
		r = prev;
		pick = $urandom_range(99);
		if (pick < 10) begin
			r = RPT_W'({$urandom, $urandom});
		end else if (pick >= 30) begin
			s = $urandom_range(5);
			if ($urandom_range(2) == 0) begin
				r[8*s+8 +: 8] = 8'h00;
			end else if ($urandom_range(19) == 0) begin
				// copy another slot to get a duplicate usage
				r[8*s+8 +: 8] = r[8*$urandom_range(5)+8 +: 8];
			end else begin
				r[8*s+8 +: 8] = pick_usage();
			end
			if ($urandom_range(9) < 3) begin
				b = $urandom_range(7);
				r[b] = ~r[b];
			end
		end
		return r;
	endfunction

	// Hold off until the driver is empty and every byte has come home, then let
	// a report that says nothing finish too.
	task automatic drain();
		while (reports_to_send.size() != 0 || s_tvalid || pending_scancodes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_repeat_delay(input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		kb_delay = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input logic [7:0] delay, input logic calm);
		logic [RPT_W-1:0] r;
		set_repeat_delay(delay);
		steady = calm;
		r = '0;
		for (int n = 0; n < RANDOM_RUN; n++) begin
			r = next_report(r);
			reports_to_send.push_back(r);
		end
		// release everything so the next phase starts from an empty list
		reports_to_send.push_back('0);
		drain();
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Cycle limit
	// ------------------------------------------------------------------
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		reset_keyboard_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default delay of 16: silence, e0 keys, Pause, every modifier both ways
		reports_to_send.push_back(report(8'h00, 0, 0, 0, 0, 0, 0));
		reports_to_send.push_back(report(8'h00, U_A, 0, 0, 0, 0, 0));
		reports_to_send.push_back(report(8'h01, U_A, U_RIGHT, 0, 0, 0, 0));
		reports_to_send.push_back(report(8'hff, U_A, U_RIGHT, U_PAUSE, 0, 0, 0));
		reports_to_send.push_back(report(8'h00, U_PAUSE, U_RIGHT, 0, 0, 0, 0));
		reports_to_send.push_back(report(8'h00, 0, 0, 0, 0, 0, 0));
		// Silent usages are held but say nothing
		reports_to_send.push_back(report(8'h00, 1, 2, 3, U_NONUS, U_BEYOND, 8'hff));
		reports_to_send.push_back(report(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		// Duplicate usages count as separate keys
		reports_to_send.push_back(report(8'h00, U_PAUSE, U_PAUSE, U_PAUSE, U_PAUSE, U_PAUSE,
			U_PAUSE));
		reports_to_send.push_back(report(8'h00, U_PAUSE, U_PAUSE, U_PAUSE, U_PAUSE, U_PAUSE,
			U_PAUSE));
		reports_to_send.push_back(report(8'h00, U_PRTSC, U_KP_DIV, U_KP_ENT, 0, 0, 0));
		reports_to_send.push_back(report(8'h00, 0, 0, 0, 0, 0, 0));
		drain();

		// Delay of zero: repeat in the very report that presses the key
		set_repeat_delay(8'd0);
		reports_to_send.push_back(report(8'h00, U_A, 0, 0, 0, 0, 0));
		reports_to_send.push_back(report(8'h00, U_A, 0, 0, 0, 0, 0));
		reports_to_send.push_back(report(8'h00, U_A, U_B, 0, 0, 0, 0));
		// releasing the newest key switches repeat off
		reports_to_send.push_back(report(8'h00, U_A, 0, 0, 0, 0, 0));
		reports_to_send.push_back(report(8'h00, 0, 0, 0, 0, 0, 0));
		drain();

		// Delay of 255: a press disables repeat outright
		set_repeat_delay(8'hff);
		reports_to_send.push_back(report(8'h00, U_A, 0, 0, 0, 0, 0));
		reports_to_send.push_back(report(8'h00, U_A, 0, 0, 0, 0, 0));
		reports_to_send.push_back(report(8'h00, 0, 0, 0, 0, 0, 0));
		drain();

		// Short delay held long enough for repeat to fire and keep firing
		set_repeat_delay(8'd2);
		for (int n = 0; n < 4; n++) begin
			reports_to_send.push_back(report(8'h00, U_ONE, 0, 0, 0, 0, 0));
		end
		reports_to_send.push_back(report(8'h00, 0, 0, 0, 0, 0, 0));
		drain();

		// Random typing under several delays, one phase without any idling
		random_phase(8'd3, 1'b0);
		random_phase(8'd254, 1'b1);
		random_phase(8'd0, 1'b0);
		random_phase(8'($urandom_range(1, 253)), 1'b0);
		random_phase(8'd1, 1'b0);

		if (error_count == 0 && pending_scancodes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
